[rtl/marching_squares_cell_isoline_defines.svh]
// Assertion macros for the isoline RTL, used by msci_seg_out.
`ifndef MARCHING_SQUARES_CELL_ISOLINE_DEFINES_SVH
`define MARCHING_SQUARES_CELL_ISOLINE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MSCI_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("msci assertion failed");

// next-cycle implication, disabled in reset
`define MSCI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("msci assertion failed");

`endif

[rtl/msci_pkg.sv]
// Shared types, constants and tables for the isoline cell block.
`default_nettype none
package msci_pkg;
    localparam int FRAC_BITS     = 16;
    localparam int VALUE_BITS    = 32;
    localparam int IDX_BITS      = 12;
    localparam int COORD_BITS    = 29;
    localparam int FRAC_W        = FRAC_BITS + 1;
    localparam int DIV_STEPS     = FRAC_BITS + 1;
    localparam int DIV_PER_STAGE = 3;
    localparam int DIV_STAGES    = (DIV_STEPS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
    localparam int EDGE_LAT      = DIV_STAGES + 2;

    typedef enum logic [2:0] {
        E_TOP, E_RIGHT, E_BOTTOM, E_LEFT, E_NONE
    } t_edge;

    typedef enum logic [1:0] {
        FK_HALF, FK_ZERO, FK_ONE, FK_DIV
    } t_frac_kind;

    typedef struct packed {
        t_edge a0;
        t_edge a1;
        t_edge b0;
        t_edge b1;
    } t_seg_plan;

    typedef struct packed {
        logic [3:0]          cs;
        logic [IDX_BITS-1:0] col;
        logic [IDX_BITS-1:0] row;
    } t_cell_info;

    function automatic t_seg_plan seg_plan(input logic [3:0] cs);
        t_seg_plan p;
        p = '{E_NONE, E_NONE, E_NONE, E_NONE};
        case (cs)
            4'd1, 4'd14: p = '{E_TOP, E_LEFT, E_NONE, E_NONE};
            4'd2, 4'd13: p = '{E_TOP, E_RIGHT, E_NONE, E_NONE};
            4'd3, 4'd12: p = '{E_LEFT, E_RIGHT, E_NONE, E_NONE};
            4'd4, 4'd11: p = '{E_RIGHT, E_BOTTOM, E_NONE, E_NONE};
            4'd5:        p = '{E_TOP, E_LEFT, E_RIGHT, E_BOTTOM};
            4'd6, 4'd9:  p = '{E_TOP, E_BOTTOM, E_NONE, E_NONE};
            4'd7, 4'd8:  p = '{E_LEFT, E_BOTTOM, E_NONE, E_NONE};
            4'd10:       p = '{E_TOP, E_RIGHT, E_LEFT, E_BOTTOM};
            default:     p = '{E_NONE, E_NONE, E_NONE, E_NONE};
        endcase
        return p;
    endfunction
endpackage
`default_nettype wire

[rtl/msci_edge_div.sv]
// Pipelined interpolation fraction for one cell edge.
`default_nettype none
module msci_edge_div (
    input  wire logic                                i_clk,
    input  wire logic                                i_en,
    input  wire logic signed [msci_pkg::VALUE_BITS-1:0] i_v0,
    input  wire logic signed [msci_pkg::VALUE_BITS-1:0] i_v1,
    input  wire logic signed [msci_pkg::VALUE_BITS-1:0] i_level,
    output logic [msci_pkg::FRAC_W-1:0]              o_frac
);
    localparam int VB = msci_pkg::VALUE_BITS;
    localparam int NS = msci_pkg::DIV_STAGES;

    logic signed [VB:0] r_num, r_den;
    logic signed [VB:0] n_num, n_den;

    logic signed [VB:0] num_a, den_a;
    msci_pkg::t_frac_kind kind_c;

    msci_pkg::t_frac_kind r_kind [NS+1];
    logic [VB-1:0]        r_n    [NS+1];
    logic [VB-1:0]        r_d    [NS+1];
    logic [msci_pkg::DIV_STEPS-1:0] r_q [NS+1];

    assign n_den = {i_v1[VB-1], i_v1} - {i_v0[VB-1], i_v0};
    assign n_num = {i_level[VB-1], i_level} - {i_v0[VB-1], i_v0};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= n_num;
            r_den <= n_den;
        end
    end

    always_comb begin
        if (r_den[VB]) begin
            den_a = -r_den;
            num_a = -r_num;
        end else begin
            den_a = r_den;
            num_a = r_num;
        end
        if (r_den == '0)
            kind_c = msci_pkg::FK_HALF;
        else if (num_a[VB] || num_a == '0)
            kind_c = msci_pkg::FK_ZERO;
        else if (num_a >= den_a)
            kind_c = msci_pkg::FK_ONE;
        else
            kind_c = msci_pkg::FK_DIV;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_kind[0] <= kind_c;
            r_n[0]    <= num_a[VB-1:0];
            r_d[0]    <= den_a[VB-1:0];
            r_q[0]    <= '0;
        end
    end

    for (genvar g = 0; g < NS; g++) begin : g_div
        logic [VB-1:0] n_nr;
        logic [msci_pkg::DIV_STEPS-1:0] n_qr;
        always_comb begin
            logic [VB:0] t;
            n_nr = r_n[g];
            n_qr = r_q[g];
            for (int k = 0; k < msci_pkg::DIV_PER_STAGE; k++) begin
                if (g * msci_pkg::DIV_PER_STAGE + k < msci_pkg::DIV_STEPS) begin
                    t    = {n_nr, 1'b0};
                    n_qr = {n_qr[msci_pkg::DIV_STEPS-2:0], 1'b0};
                    if (t >= {1'b0, r_d[g]}) begin
                        t       = t - {1'b0, r_d[g]};
                        n_qr[0] = 1'b1;
                    end
                    n_nr = t[VB-1:0];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_kind[g+1] <= r_kind[g];
                r_n[g+1]    <= n_nr;
                r_d[g+1]    <= r_d[g];
                r_q[g+1]    <= n_qr;
            end
        end
    end

    always_comb begin
        logic [msci_pkg::DIV_STEPS:0] qr;
        qr = {1'b0, r_q[NS]} + 1'b1;
        unique case (r_kind[NS])
            msci_pkg::FK_HALF: o_frac = msci_pkg::FRAC_W'(1) << (msci_pkg::FRAC_BITS - 1);
            msci_pkg::FK_ZERO: o_frac = '0;
            msci_pkg::FK_ONE:  o_frac = msci_pkg::FRAC_W'(1) << msci_pkg::FRAC_BITS;
            default:           o_frac = qr[msci_pkg::DIV_STEPS:1];
        endcase
    end
endmodule
`default_nettype wire

[rtl/msci_seg_out.sv]
// Segment assembly and output register, one or two beats per cell that has a segment.
`default_nettype none
`include "marching_squares_cell_isoline_defines.svh"
module msci_seg_out (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire msci_pkg::t_cell_info         i_info,
    input  wire logic [msci_pkg::FRAC_W-1:0]  i_fr_top,
    input  wire logic [msci_pkg::FRAC_W-1:0]  i_fr_right,
    input  wire logic [msci_pkg::FRAC_W-1:0]  i_fr_bottom,
    input  wire logic [msci_pkg::FRAC_W-1:0]  i_fr_left,
    output logic                              o_en,
    output logic                              o_valid,
    input  wire logic                         i_tready,
    output logic [4*msci_pkg::COORD_BITS-1:0] o_seg,
    output logic                              o_last
);
    localparam int CB = msci_pkg::COORD_BITS;

    msci_pkg::t_seg_plan plan;
    logic load, can_take, last_now;
    logic r_ov, r_idx, r_two;
    logic [4*CB-1:0] r_seg0, r_seg1;
    logic [4*CB-1:0] n_seg0, n_seg1;

    function automatic logic [2*CB-1:0] point(input msci_pkg::t_edge e,
        input msci_pkg::t_cell_info c, input logic [msci_pkg::FRAC_W-1:0] ft,
        input logic [msci_pkg::FRAC_W-1:0] fr, input logic [msci_pkg::FRAC_W-1:0] fb,
        input logic [msci_pkg::FRAC_W-1:0] fl);
        logic [CB-1:0] bx, by, one, x, y;
        bx  = CB'({c.col, {msci_pkg::FRAC_BITS{1'b0}}});
        by  = CB'({c.row, {msci_pkg::FRAC_BITS{1'b0}}});
        one = CB'(1) << msci_pkg::FRAC_BITS;
        unique case (e)
            msci_pkg::E_TOP:    begin x = bx + CB'(ft); y = by; end
            msci_pkg::E_RIGHT:  begin x = bx + one; y = by + CB'(fr); end
            msci_pkg::E_BOTTOM: begin x = bx + CB'(fb); y = by + one; end
            default:            begin x = bx; y = by + CB'(fl); end
        endcase
        return {y, x};
    endfunction

    assign plan     = msci_pkg::seg_plan(i_info.cs);
    assign last_now = !r_two || r_idx;
    assign can_take = !r_ov || (i_tready && last_now);
    assign load     = can_take && i_valid && plan.a0 != msci_pkg::E_NONE;
    assign o_en     = can_take;

    assign n_seg0 = {point(plan.a1, i_info, i_fr_top, i_fr_right, i_fr_bottom, i_fr_left),
                     point(plan.a0, i_info, i_fr_top, i_fr_right, i_fr_bottom, i_fr_left)};
    assign n_seg1 = {point(plan.b1, i_info, i_fr_top, i_fr_right, i_fr_bottom, i_fr_left),
                     point(plan.b0, i_info, i_fr_top, i_fr_right, i_fr_bottom, i_fr_left)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_idx <= 1'b0;
        end else if (can_take) begin
            r_ov  <= load;
            r_idx <= 1'b0;
        end else if (i_tready) begin
            r_idx <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_seg0 <= n_seg0;
            r_seg1 <= n_seg1;
            r_two  <= plan.b0 != msci_pkg::E_NONE;
        end
    end

    assign o_valid = r_ov;
    assign o_seg   = r_idx ? r_seg1 : r_seg0;
    assign o_last  = last_now;

    `MSCI_ASSERT_NEXT(a_second_follows, r_ov && !last_now && i_tready, r_ov && r_idx)
    `MSCI_ASSERT_NEXT(a_load_shows, load, r_ov && !r_idx)
    `MSCI_ASSERT_IMPL(a_idx_two, r_ov && r_idx, r_two)
endmodule
`default_nettype wire

[rtl/marching_squares_cell_isoline.sv]
// Top level of the marching-squares isoline cell block.
// Usage:
//  Slave stream takes one grid cell per beat: four signed corner samples,
//  column and row. The user writes the contour level via i_cfg_we/i_cfg_wdata
//  only while the block is idle; this is not enforced. Reset sets it to zero.
//  Master stream gives one isoline segment per beat, tlast on the final
//  segment of its cell. Empty and full cells give no beat.
//  Path: input register, set-up and divider stages, output register.
//  Throughput: one cell per cycle while i_m_tready is high; a saddle cell
//  holds the output register for both beats, delaying its successor. Set
//  by the single output register that sends both segments of a cell.
//  The edge fractions come from four 17-step dividers cut into 6 stages of
//  up to 3 steps after two set-up stages; all stages advance together.
//  Stall: while a beat waits with tready low, the whole pipeline freezes
//  and o_s_tready is low; nothing is lost or repeated.
//  Reset: synchronous, active low; clears all valid bits and the level.
`default_nettype none
module marching_squares_cell_isoline (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [31:0]  i_cfg_wdata,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // tl[31:0], tr[63:32], bl[95:64], br[127:96], col[139:128], row[151:140]
    input  wire logic [151:0] i_s_tdata,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // start_x[28:0], start_y[57:29], end_x[86:58], end_y[115:87], zero fill
    output logic [119:0]      o_m_tdata,
    output logic              o_m_tlast
);
    localparam int VB = msci_pkg::VALUE_BITS;
    localparam int IB = msci_pkg::IDX_BITS;
    localparam int L  = msci_pkg::EDGE_LAT;

    logic en;
    logic signed [VB-1:0] r_level;
    logic r_s0_v;
    logic signed [VB-1:0] r_tl, r_tr, r_bl, r_br;
    logic [IB-1:0] r_col, r_row;
    logic r_sd_v [L];
    msci_pkg::t_cell_info r_sd [L];
    msci_pkg::t_cell_info n_info;
    logic [msci_pkg::FRAC_W-1:0] fr_t, fr_r, fr_b, fr_l;
    logic [4*msci_pkg::COORD_BITS-1:0] seg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_level <= '0;
        else if (i_cfg_we)
            r_level <= i_cfg_wdata;
    end

    assign o_s_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
            for (int i = 0; i < L; i++) r_sd_v[i] <= 1'b0;
        end else if (en) begin
            r_s0_v    <= i_s_tvalid;
            r_sd_v[0] <= r_s0_v;
            for (int i = 1; i < L; i++) r_sd_v[i] <= r_sd_v[i-1];
        end
    end

    assign n_info.cs  = {r_bl >= r_level, r_br >= r_level, r_tr >= r_level, r_tl >= r_level};
    assign n_info.col = r_col;
    assign n_info.row = r_row;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tl  <= i_s_tdata[31:0];
            r_tr  <= i_s_tdata[63:32];
            r_bl  <= i_s_tdata[95:64];
            r_br  <= i_s_tdata[127:96];
            r_col <= i_s_tdata[139:128];
            r_row <= i_s_tdata[151:140];
            r_sd[0] <= n_info;
            for (int i = 1; i < L; i++) r_sd[i] <= r_sd[i-1];
        end
    end

    msci_edge_div u_top (.i_clk(i_clk), .i_en(en), .i_v0(r_tl), .i_v1(r_tr),
                         .i_level(r_level), .o_frac(fr_t));
    msci_edge_div u_right (.i_clk(i_clk), .i_en(en), .i_v0(r_tr), .i_v1(r_br),
                           .i_level(r_level), .o_frac(fr_r));
    msci_edge_div u_bottom (.i_clk(i_clk), .i_en(en), .i_v0(r_bl), .i_v1(r_br),
                            .i_level(r_level), .o_frac(fr_b));
    msci_edge_div u_left (.i_clk(i_clk), .i_en(en), .i_v0(r_tl), .i_v1(r_bl),
                          .i_level(r_level), .o_frac(fr_l));

    msci_seg_out u_out (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(r_sd_v[L-1]), .i_info(r_sd[L-1]),
        .i_fr_top(fr_t), .i_fr_right(fr_r), .i_fr_bottom(fr_b), .i_fr_left(fr_l),
        .o_en(en), .o_valid(o_m_tvalid), .i_tready(i_m_tready),
        .o_seg(seg), .o_last(o_m_tlast)
    );

    assign o_m_tdata = {4'd0, seg};
endmodule
`default_nettype wire
